/* design/apbu_pkg.sv */
// Types, codes and helpers shared by the ARGB blend pipeline.
// No dependencies.
`default_nettype none

package apbu_pkg;

  typedef enum logic [1:0] {
    MODE_FILL = 2'd0,
    MODE_XRGB = 2'd1,
    MODE_OVER = 2'd2,
    MODE_NONE = 2'd3
  } blend_mode_e;

  localparam logic [1:0] REG_BLEND_MODE  = 2'd0;
  localparam logic [1:0] REG_BLEND_ALPHA = 2'd1;
  localparam logic [1:0] REG_FILL_COLOR  = 2'd2;

  localparam logic [7:0] CH_MAX = 8'hFF;

  typedef struct packed {
    logic [31:0] src_pixel;
    logic [31:0] dst_pixel;
  } in_t;

  typedef struct packed {
    logic        write_enable;
    logic [31:0] out_pixel;
  } out_t;

  typedef struct packed {
    blend_mode_e blend_mode;
    logic [7:0]  blend_alpha;
    logic [31:0] fill_color;
  } cfg_t;

  // products
  typedef struct packed {
    logic             we;
    blend_mode_e      mode;
    logic             pass;
    logic [31:0]      direct;
    logic [31:0]      dst;
    logic [3:0][15:0] prod_a;
    logic [3:0][15:0] prod_b;
    logic [15:0]      prod_t;
  } s1_t;

  // sums and first quotients
  typedef struct packed {
    logic             we;
    blend_mode_e      mode;
    logic             pass;
    logic [31:0]      direct;
    logic [31:0]      dst;
    logic [3:0][15:0] lerp_sum;
    logic [3:0][7:0]  sa_div;
    logic [7:0]       inv_t;
  } s2_t;

  // lerp result and destination products
  typedef struct packed {
    logic             we;
    blend_mode_e      mode;
    logic             pass;
    logic [31:0]      direct;
    logic [3:0][7:0]  lerp_q;
    logic [3:0][7:0]  sa_div;
    logic [3:0][15:0] dinv;
  } s3_t;

  // floor(x/255), exact for x <= 65279
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

endpackage

`default_nettype wire

/* design/apbu_mul.sv */
// Stage 1: channel products against alpha and its complement.
// Uses apbu_pkg.
`default_nettype none

module apbu_mul (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire apbu_pkg::cfg_t cfg_i,
  input  wire logic          valid_i,
  output logic               stall_o,
  input  wire apbu_pkg::in_t data_i,
  output logic               valid_o,
  input  wire logic          stall_i,
  output apbu_pkg::s1_t      data_o
);

  logic          valid_q;
  apbu_pkg::s1_t data_q, data_d;
  logic [7:0]    a, inv_a;
  logic [31:0]   c;

  always_comb begin
    a     = cfg_i.blend_alpha;
    inv_a = apbu_pkg::CH_MAX - a;
    c     = (cfg_i.blend_mode == apbu_pkg::MODE_FILL) ? cfg_i.fill_color
                                                      : data_i.src_pixel;
    data_d.we     = (a != 8'd0) && (cfg_i.blend_mode != apbu_pkg::MODE_NONE);
    data_d.mode   = cfg_i.blend_mode;
    data_d.pass   = (a == apbu_pkg::CH_MAX) && (cfg_i.blend_mode != apbu_pkg::MODE_OVER);
    data_d.direct = (cfg_i.blend_mode == apbu_pkg::MODE_FILL) ? cfg_i.fill_color
                    : {apbu_pkg::CH_MAX, data_i.src_pixel[23:0]};
    data_d.dst    = data_i.dst_pixel;
    for (int k = 0; k < 4; k++) begin
      data_d.prod_a[k] = c[8*k +: 8] * a;
      data_d.prod_b[k] = data_i.dst_pixel[8*k +: 8] * inv_a;
    end
    data_d.prod_t = data_i.src_pixel[31:24] * a;
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

/* design/apbu_div.sv */
// Stage 2: lerp sums, source quotients and inverse coverage.
// Uses apbu_pkg.
`default_nettype none

module apbu_div (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               stall_o,
  input  wire apbu_pkg::s1_t data_i,
  output logic               valid_o,
  input  wire logic          stall_i,
  output apbu_pkg::s2_t      data_o
);

  logic          valid_q;
  apbu_pkg::s2_t data_q, data_d;

  always_comb begin
    data_d.we     = data_i.we;
    data_d.mode   = data_i.mode;
    data_d.pass   = data_i.pass;
    data_d.direct = data_i.direct;
    data_d.dst    = data_i.dst;
    for (int k = 0; k < 4; k++) begin
      data_d.lerp_sum[k] = data_i.prod_a[k] + data_i.prod_b[k];
      data_d.sa_div[k]   = apbu_pkg::div255(data_i.prod_a[k]);
    end
    data_d.inv_t = apbu_pkg::CH_MAX - apbu_pkg::div255(data_i.prod_t);
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

/* design/apbu_mix.sv */
// Stage 3: lerp quotients and destination times inverse coverage.
// Uses apbu_pkg.
`default_nettype none

module apbu_mix (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               stall_o,
  input  wire apbu_pkg::s2_t data_i,
  output logic               valid_o,
  input  wire logic          stall_i,
  output apbu_pkg::s3_t      data_o
);

  logic          valid_q;
  apbu_pkg::s3_t data_q, data_d;

  always_comb begin
    data_d.we     = data_i.we;
    data_d.mode   = data_i.mode;
    data_d.pass   = data_i.pass;
    data_d.direct = data_i.direct;
    data_d.sa_div = data_i.sa_div;
    for (int k = 0; k < 4; k++) begin
      data_d.lerp_q[k] = apbu_pkg::div255(data_i.lerp_sum[k]);
      data_d.dinv[k]   = data_i.dst[8*k +: 8] * data_i.inv_t;
    end
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

/* design/apbu_fin.sv */
// Stage 4: src-over sum with saturation, result select, output register.
// Uses apbu_pkg.
`default_nettype none

module apbu_fin (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               stall_o,
  input  wire apbu_pkg::s3_t data_i,
  output logic               valid_o,
  input  wire logic          stall_i,
  output apbu_pkg::out_t     data_o
);

  logic           valid_q;
  apbu_pkg::out_t data_q, data_d;
  logic [31:0]    over_px;
  logic [8:0]     sum;

  always_comb begin
    over_px = '0;
    for (int k = 0; k < 4; k++) begin
      sum = {1'b0, data_i.sa_div[k]} + {1'b0, apbu_pkg::div255(data_i.dinv[k])};
      over_px[8*k +: 8] = sum[8] ? apbu_pkg::CH_MAX : sum[7:0];
    end
    data_d.write_enable = data_i.we;
    if (!data_i.we) begin
      data_d.out_pixel = '0;
    end else if (data_i.pass) begin
      data_d.out_pixel = data_i.direct;
    end else begin
      case (data_i.mode)
        apbu_pkg::MODE_FILL: data_d.out_pixel = data_i.lerp_q;
        apbu_pkg::MODE_XRGB: data_d.out_pixel = {apbu_pkg::CH_MAX, data_i.lerp_q[2:0]};
        apbu_pkg::MODE_OVER: data_d.out_pixel = over_px;
        default:             data_d.out_pixel = '0;
      endcase
    end
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

/* design/argb_pixel_blend_unit.sv */
// ARGB8888 pixel blender: fill lerp, opaque XRGB source, premultiplied src-over.
// Top level; uses apbu_pkg, apbu_mul, apbu_div, apbu_mix, apbu_fin.
//
// Input channel: in_valid_i / in_stall_o carry a source and destination pixel.
// A transfer takes place on a clock edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i carry the write flag and the
// blended pixel, exactly one result per input transfer, in order.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i
// (0 mode, 1 alpha, 2 fill color); write only while the pipeline is empty.
// An input transfer passes through four register stages (products, quotients,
// second products, final sum) to out_valid_o; throughput is one pixel per
// cycle while out_stall_i is low, each stage taking a new pixel every cycle.
// Reset clears all valid bits and loads mode 0, alpha 255, fill color 0.
// When the receiver stalls, the output holds and stall propagates back one
// stage per full register; empty stages keep filling, so nothing is lost.
`default_nettype none

module argb_pixel_blend_unit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [31:0]    cfg_wdata_i,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire apbu_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output apbu_pkg::out_t      out_data_o
);

  apbu_pkg::cfg_t cfg_q;
  logic           v1, v2, v3;
  logic           st1, st2, st3;
  apbu_pkg::s1_t  d1;
  apbu_pkg::s2_t  d2;
  apbu_pkg::s3_t  d3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blend_mode  <= apbu_pkg::MODE_FILL;
      cfg_q.blend_alpha <= apbu_pkg::CH_MAX;
      cfg_q.fill_color  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        apbu_pkg::REG_BLEND_MODE:  cfg_q.blend_mode  <= apbu_pkg::blend_mode_e'(cfg_wdata_i[1:0]);
        apbu_pkg::REG_BLEND_ALPHA: cfg_q.blend_alpha <= cfg_wdata_i[7:0];
        apbu_pkg::REG_FILL_COLOR:  cfg_q.fill_color  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  apbu_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (in_data_i),
    .valid_o (v1),
    .stall_i (st1),
    .data_o  (d1)
  );

  apbu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .stall_o (st1),
    .data_i  (d1),
    .valid_o (v2),
    .stall_i (st2),
    .data_o  (d2)
  );

  apbu_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .stall_o (st2),
    .data_i  (d2),
    .valid_o (v3),
    .stall_i (st3),
    .data_o  (d3)
  );

  apbu_fin u_fin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3),
    .stall_o (st3),
    .data_i  (d3),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* tb/argb_pixel_blend_unit_tb.sv */
// Testbench for argb_pixel_blend_unit: directed table, then random phases per mode.
// Results are checked against table values or an in-bench predictor. Uses apbu_pkg.
`default_nettype none

module argb_pixel_blend_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned FULL = 255;

  typedef struct packed {
    apbu_pkg::blend_mode_e mode;
    logic [7:0]            alpha;
    logic [31:0]           fill;
    logic [31:0]           src;
    logic [31:0]           dst;
    logic                  known;
    logic                  we;
    logic [31:0]           pix;
  } dir_row_t;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           cfg_we_i;
  logic [1:0]     cfg_index_i;
  logic [31:0]    cfg_wdata_i;
  logic           in_valid_i;
  logic           in_stall_o;
  apbu_pkg::in_t  in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  apbu_pkg::out_t out_data_o;

  apbu_pkg::blend_mode_e mode_q;
  logic [7:0]            alpha_q;
  logic [31:0]           fill_q;

  apbu_pkg::out_t pending_px_q [$];
  dir_row_t       dir_rows [19];
  int             err_cnt = 0;
  bit             tx_idle_en = 1'b1;
  bit             rx_idle_en = 1'b1;
  bit             hold_req = 1'b0;

  argb_pixel_blend_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [7:0] lerp_chan(input int unsigned c, input int unsigned d,
                                           input int unsigned a);
    return 8'((c * a + d * (FULL - a)) / FULL);
  endfunction

  function automatic apbu_pkg::out_t blend_pixel(input apbu_pkg::in_t px);
    apbu_pkg::out_t r;
    int unsigned    a;
    int unsigned    t;
    int unsigned    inv_t;
    int unsigned    v;
    int             sh;
    r = '0;
    a = alpha_q;
    if (a == 0 || mode_q == apbu_pkg::MODE_NONE) return r;
    r.write_enable = 1'b1;
    case (mode_q)
      apbu_pkg::MODE_FILL: begin
        if (a == FULL) r.out_pixel = fill_q;
        else
          for (sh = 0; sh < 32; sh += 8)
            r.out_pixel[sh +: 8] = lerp_chan(fill_q[sh +: 8], px.dst_pixel[sh +: 8], a);
      end
      apbu_pkg::MODE_XRGB: begin
        r.out_pixel[31:24] = 8'hFF;
        if (a == FULL) r.out_pixel[23:0] = px.src_pixel[23:0];
        else
          for (sh = 0; sh < 24; sh += 8)
            r.out_pixel[sh +: 8] = lerp_chan(px.src_pixel[sh +: 8], px.dst_pixel[sh +: 8], a);
      end
      default: begin
        t = (int'(px.src_pixel[31:24]) * a) / FULL;
        inv_t = FULL - t;
        for (sh = 0; sh < 32; sh += 8) begin
          v = (int'(px.src_pixel[sh +: 8]) * a) / FULL
              + (int'(px.dst_pixel[sh +: 8]) * inv_t) / FULL;
          r.out_pixel[sh +: 8] = (v > FULL) ? 8'hFF : 8'(v);
        end
      end
    endcase
    return r;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  function automatic int next_gap();
    return (tx_idle_en && $urandom_range(0, 3) == 0) ? gap_len() : 0;
  endfunction

  function automatic logic [7:0] rand_chan();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return 8'h00;
    if (r < 4) return 8'hFF;
    return 8'($urandom);
  endfunction

  // premultiplied pixels keep every color channel at or below alpha
  function automatic logic [31:0] rand_pixel(input bit premul);
    logic [31:0] p;
    int          i;
    p[31:24] = rand_chan();
    for (i = 0; i < 3; i++)
      p[i*8 +: 8] = premul ? 8'($urandom_range(0, p[31:24])) : rand_chan();
    return p;
  endfunction

  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 9))
      0: return 8'h01;
      1: return 8'hFE;
      2: return 8'hFF;
      default: return 8'($urandom_range(1, 254));
    endcase
  endfunction

  function automatic logic [31:0] pick_fill();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      apbu_pkg::REG_BLEND_MODE:  mode_q  = apbu_pkg::blend_mode_e'(data[1:0]);
      apbu_pkg::REG_BLEND_ALPHA: alpha_q = data[7:0];
      apbu_pkg::REG_FILL_COLOR:  fill_q  = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(input apbu_pkg::blend_mode_e m, input logic [7:0] al,
                            input logic [31:0] fc);
    cfg_write(apbu_pkg::REG_BLEND_MODE, {30'($urandom), m});
    cfg_write(apbu_pkg::REG_BLEND_ALPHA, {24'($urandom), al});
    cfg_write(apbu_pkg::REG_FILL_COLOR, fc);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_px_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_pixel(input apbu_pkg::in_t px, input apbu_pkg::out_t want,
                            input int gap);
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_px_q.push_back(want);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin : out_check
    apbu_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_px_q.size() == 0) begin
        $error("out transfer with no pixel pending: %h", out_data_o);
        err_cnt++;
      end else begin
        want = pending_px_q.pop_front();
        if (out_data_o.write_enable !== want.write_enable) begin
          $error("write_enable: expected %0b, got %0b", want.write_enable,
                 out_data_o.write_enable);
          err_cnt++;
        end
        if (out_data_o.out_pixel !== want.out_pixel) begin
          $error("out_pixel: expected %h, got %h", want.out_pixel, out_data_o.out_pixel);
          err_cnt++;
        end
      end
    end
  end

  initial begin : rx_proc
    int n;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (60) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        n = gap_len();
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stim
    apbu_pkg::in_t         px;
    apbu_pkg::out_t        want;
    int                    ph;
    int                    k;
    int                    gap;
    apbu_pkg::blend_mode_e m;
    logic [7:0]            al;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    mode_q      = apbu_pkg::MODE_FILL;
    alpha_q     = 8'hFF;
    fill_q      = '0;

    dir_rows = '{
      '{apbu_pkg::MODE_FILL, 8'd255, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        1'b1, 1'b1, 32'h0000_0000},
      '{apbu_pkg::MODE_FILL, 8'd255, 32'hDEAD_BEEF, 32'h0000_0000, 32'h0000_0000,
        1'b1, 1'b1, 32'hDEAD_BEEF},
      '{apbu_pkg::MODE_FILL, 8'd128, 32'hFF00_FF00, 32'h0000_0000, 32'h00FF_00FF,
        1'b0, 1'b0, 32'h0},
      '{apbu_pkg::MODE_FILL, 8'd1,   32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
        1'b1, 1'b1, 32'h0101_0101},
      '{apbu_pkg::MODE_FILL, 8'd254, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
        1'b1, 1'b1, 32'h0101_0101},
      '{apbu_pkg::MODE_FILL, 8'd0,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        1'b1, 1'b0, 32'h0},
      '{apbu_pkg::MODE_XRGB, 8'd255, 32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFF,
        1'b1, 1'b1, 32'hFF34_5678},
      '{apbu_pkg::MODE_XRGB, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
        1'b1, 1'b1, 32'hFFFF_FFFF},
      '{apbu_pkg::MODE_XRGB, 8'd255, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
        1'b1, 1'b1, 32'hFF00_0000},
      '{apbu_pkg::MODE_XRGB, 8'd100, 32'hFFFF_FFFF, 32'h80C0_407F, 32'h3355_AAFF,
        1'b0, 1'b0, 32'h0},
      '{apbu_pkg::MODE_XRGB, 8'd0,   32'hFFFF_FFFF, 32'h1234_5678, 32'h9ABC_DEF0,
        1'b1, 1'b0, 32'h0},
      '{apbu_pkg::MODE_OVER, 8'd255, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        1'b1, 1'b1, 32'hFFFF_FFFF},
      '{apbu_pkg::MODE_OVER, 8'd255, 32'h0000_0000, 32'h00FF_FFFF, 32'hFFFF_FFFF,
        1'b1, 1'b1, 32'hFFFF_FFFF},
      '{apbu_pkg::MODE_OVER, 8'd255, 32'h0000_0000, 32'h0000_0000, 32'h8080_8080,
        1'b1, 1'b1, 32'h8080_8080},
      '{apbu_pkg::MODE_OVER, 8'd128, 32'h0000_0000, 32'h80FF_4020, 32'h1122_3344,
        1'b0, 1'b0, 32'h0},
      '{apbu_pkg::MODE_OVER, 8'd1,   32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
        1'b1, 1'b1, 32'h0101_0101},
      '{apbu_pkg::MODE_OVER, 8'd0,   32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
        1'b1, 1'b0, 32'h0},
      '{apbu_pkg::MODE_NONE, 8'd255, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        1'b1, 1'b0, 32'h0},
      '{apbu_pkg::MODE_NONE, 8'd0,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
        1'b1, 1'b0, 32'h0}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // index 3 is not a register; the reset settings must survive it
    cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
    cfg_we_i <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != mode_q || dir_rows[i].alpha != alpha_q ||
          dir_rows[i].fill != fill_q) begin
        wait_idle();
        set_config(dir_rows[i].mode, dir_rows[i].alpha, dir_rows[i].fill);
      end
      px.src_pixel = dir_rows[i].src;
      px.dst_pixel = dir_rows[i].dst;
      if (dir_rows[i].known) begin
        want.write_enable = dir_rows[i].we;
        want.out_pixel    = dir_rows[i].pix;
      end else begin
        want = blend_pixel(px);
      end
      send_pixel(px, want, next_gap());
    end

    for (ph = 0; ph < 10; ph++) begin
      wait_idle();
      m  = (ph == 9) ? apbu_pkg::MODE_NONE : apbu_pkg::blend_mode_e'(ph % 3);
      al = (ph < 3) ? 8'hFF : (ph == 8) ? 8'h00 : pick_alpha();
      set_config(m, al, pick_fill());
      tx_idle_en = (ph % 4 != 1);
      rx_idle_en = (ph % 3 != 2) && (ph != 4);
      for (k = 0; k < 55; k++) begin
        if (ph == 4 && k == 10) hold_req = 1'b1;
        if (ph == 6 && k == 27) wait_idle();
        px.src_pixel = rand_pixel(m == apbu_pkg::MODE_OVER && $urandom_range(0, 9) < 7);
        px.dst_pixel = rand_pixel(m == apbu_pkg::MODE_OVER && $urandom_range(0, 9) < 7);
        gap = (ph == 4 && k >= 10 && k < 40) ? 0 : next_gap();
        send_pixel(px, blend_pixel(px), gap);
      end
    end

    wait_idle();
    rx_idle_en = 1'b0;
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) $display("argb_pixel_blend_unit_tb: done, clean");
    else $display("argb_pixel_blend_unit_tb: done, errors");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("argb_pixel_blend_unit_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
design/apbu_pkg.sv
design/apbu_mul.sv
design/apbu_div.sv
design/apbu_mix.sv
design/apbu_fin.sv
design/argb_pixel_blend_unit.sv
tb/argb_pixel_blend_unit_tb.sv
